>>> rtl/core/lgs_pkg.sv
// shared types and constants for the life grid generation step block
`default_nettype none

package lgs_pkg;

  localparam int DEF_GRID_ROWS = 32;
  localparam int DEF_GRID_COLS = 32;

  localparam int COUNT_W   = 11;
  localparam int COUNT_MAX = 2047;

  localparam int S_DATA_W = 16;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 16;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_STEP = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef struct packed {
    logic capture;
    logic win_clear;
    logic sweep_rd;
    logic sweep_shift;
    logic use_rd;
    logic compute;
    logic pt_rd;
    logic pt_upd;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/lgs_datapath.sv
// grid memory, three-row window, life rule, live counter and result register
`default_nettype none

module lgs_datapath
  import lgs_pkg::*;
#(
  parameter int GRID_ROWS = DEF_GRID_ROWS,
  parameter int GRID_COLS = DEF_GRID_COLS,
  localparam int ROW_W = $clog2(GRID_ROWS),
  localparam int COL_W = $clog2(GRID_COLS)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dp_cmd_t             cmd,
  output dp_stat_t                 stat,
  input  wire logic [ROW_W-1:0]    rd_addr,
  input  wire logic [ROW_W-1:0]    wr_addr,
  input  wire logic [S_DATA_W-1:0] s_tdata,
  input  wire logic [S_USER_W-1:0] s_tuser,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata
);

  localparam int CNT_W  = $clog2(GRID_ROWS * GRID_COLS + 1);
  localparam int SAT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int NBYTES = (GRID_COLS + 7) / 8;
  localparam int PC_W   = $clog2(8 * NBYTES + 1);

  logic [GRID_COLS-1:0] mem [GRID_ROWS];
  logic [GRID_ROWS-1:0] row_valid;

  logic [1:0]           kind_q;
  logic [4:0]           row_q;
  logic [4:0]           col_q;
  logic                 alive_q;
  logic                 in_grid;
  logic [ROW_W+4:0]     row_ext;
  logic [COL_W+4:0]     col_ext;
  logic [ROW_W-1:0]     pt_row;
  logic [COL_W-1:0]     pt_col;

  logic [ROW_W-1:0]     mem_raddr;
  logic                 mem_ren;
  logic [GRID_COLS-1:0] rdata;
  logic                 rvalid;
  logic [GRID_COLS-1:0] rdata_eff;

  logic [GRID_COLS-1:0] w_prev;
  logic [GRID_COLS-1:0] w_cur;
  logic [GRID_COLS-1:0] w_nxt;
  logic [GRID_COLS-1:0] new_row;
  logic [GRID_COLS-1:0] new_q;
  logic [ROW_W-1:0]     new_addr;
  logic                 new_vld;

  logic                 load_wr;
  logic                 mem_we;
  logic [ROW_W-1:0]     mem_waddr;
  logic [GRID_COLS-1:0] mem_wdata;
  logic [GRID_COLS-1:0] pt_mask;

  logic [PC_W-1:0]      pc;
  logic [CNT_W-1:0]     acc;
  logic [SAT_W-1:0]     acc_ext;
  logic [COUNT_W-1:0]   count_sat;
  logic                 pt_bit;

  logic                 res_alive;
  logic [COUNT_W-1:0]   res_count;
  logic                 res_extinct;

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q  <= s_tuser;
      row_q   <= s_tdata[4:0];
      col_q   <= s_tdata[9:5];
      alive_q <= s_tdata[10];
    end
  end

  assign in_grid = (32'(row_q) < GRID_ROWS) && (32'(col_q) < GRID_COLS);
  assign row_ext = (ROW_W + 5)'(row_q);
  assign col_ext = (COL_W + 5)'(col_q);
  assign pt_row  = row_ext[ROW_W-1:0];
  assign pt_col  = col_ext[COL_W-1:0];

  // memory ports
  assign mem_ren   = cmd.sweep_rd || (cmd.pt_rd && in_grid);
  assign mem_raddr = cmd.sweep_rd ? rd_addr : pt_row;

  always_ff @(posedge clk) begin
    if (mem_ren) begin
      rdata  <= mem[mem_raddr];
      rvalid <= row_valid[mem_raddr];
    end
  end

  assign rdata_eff = rvalid ? rdata : '0;

  always_comb begin
    pt_mask         = '0;
    pt_mask[pt_col] = 1'b1;
  end

  assign load_wr   = cmd.pt_upd && (kind_q == KIND_LOAD) && in_grid;
  assign mem_we    = new_vld || load_wr;
  assign mem_waddr = new_vld ? new_addr : pt_row;
  assign mem_wdata = new_vld ? new_q :
                     (alive_q ? (rdata_eff | pt_mask) : (rdata_eff & ~pt_mask));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (mem_we) begin
      row_valid[mem_waddr] <= 1'b1;
    end
  end

  // three-row window
  assign w_nxt = cmd.use_rd ? rdata_eff : '0;

  always_ff @(posedge clk) begin
    if (cmd.win_clear) begin
      w_prev <= '0;
      w_cur  <= '0;
    end else if (cmd.sweep_shift) begin
      w_prev <= w_cur;
      w_cur  <= w_nxt;
    end
  end

  // b3/s23 rule over one row
  always_comb begin
    logic [GRID_COLS+1:0] pp;
    logic [GRID_COLS+1:0] cp;
    logic [GRID_COLS+1:0] np;
    logic [3:0]           n;
    pp = {1'b0, w_prev, 1'b0};
    cp = {1'b0, w_cur, 1'b0};
    np = {1'b0, w_nxt, 1'b0};
    new_row = '0;
    for (int c = 0; c < GRID_COLS; c++) begin
      n = 4'(pp[c]) + 4'(pp[c+1]) + 4'(pp[c+2]) + 4'(cp[c]) + 4'(cp[c+2])
        + 4'(np[c]) + 4'(np[c+1]) + 4'(np[c+2]);
      new_row[c] = (n == 4'd3) || (cp[c+1] && (n == 4'd2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      new_vld <= 1'b0;
    end else begin
      new_vld <= cmd.compute;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compute) begin
      new_q    <= new_row;
      new_addr <= wr_addr;
    end
  end

  // population of the written row, per byte then across bytes
  always_comb begin
    logic [NBYTES*8-1:0] padded;
    logic [3:0]          bc;
    padded = (NBYTES * 8)'(new_q);
    pc     = '0;
    for (int b = 0; b < NBYTES; b++) begin
      bc = '0;
      for (int i = 0; i < 8; i++) begin
        bc = bc + 4'(padded[b*8+i]);
      end
      pc = pc + PC_W'(bc);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_clear) begin
      acc <= '0;
    end else if (new_vld) begin
      acc <= acc + CNT_W'(pc);
    end
  end

  assign acc_ext   = SAT_W'(acc);
  assign count_sat = (acc_ext > SAT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                   : acc_ext[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.pt_upd) begin
      pt_bit <= (kind_q == KIND_READ) && in_grid && rdata_eff[pt_col];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_alive   <= 1'b0;
      res_count   <= '0;
      res_extinct <= 1'b0;
      unique case (kind_q)
        KIND_STEP: begin
          res_count   <= count_sat;
          res_extinct <= (acc == '0);
        end
        KIND_READ: begin
          res_alive <= pt_bit;
        end
        default: begin
        end
      endcase
    end
  end

  assign m_tdata = {3'b000, res_extinct, res_count, res_alive};

  assign stat.out_free = !m_tvalid || m_tready;

endmodule

`default_nettype wire

>>> rtl/core/lgs_ctrl.sv
// controller state machine for load, read and generation sweeps
`default_nettype none

module lgs_ctrl
  import lgs_pkg::*;
#(
  parameter int GRID_ROWS = DEF_GRID_ROWS,
  localparam int ROW_W = $clog2(GRID_ROWS)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_USER_W-1:0] s_tuser,
  output dp_cmd_t                  cmd,
  input  wire dp_stat_t            stat,
  output logic [ROW_W-1:0]         rd_addr,
  output logic [ROW_W-1:0]         wr_addr
);

  localparam int K_W = $clog2(GRID_ROWS + 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PRIME  = 7'b0000010,
    ST_SWEEP  = 7'b0000100,
    ST_DRAIN  = 7'b0001000,
    ST_ACCESS = 7'b0010000,
    ST_MODIFY = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t         state;
  state_t         state_next;
  logic [K_W-1:0] k;
  logic [K_W-1:0] k_next;
  logic [K_W-1:0] k_plus;
  logic [K_W-1:0] k_minus;
  logic           accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign k_plus   = k + K_W'(1);
  assign k_minus  = k - K_W'(1);
  assign rd_addr  = (state == ST_PRIME) ? '0 : k_plus[ROW_W-1:0];
  assign wr_addr  = k_minus[ROW_W-1:0];

  always_comb begin
    state_next = state;
    k_next     = k;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          unique case (kind_t'(s_tuser))
            KIND_STEP: state_next = ST_PRIME;
            KIND_LOAD, KIND_READ: state_next = ST_ACCESS;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_PRIME: begin
        cmd.win_clear = 1'b1;
        cmd.sweep_rd  = 1'b1;
        k_next        = '0;
        state_next    = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.sweep_rd    = (32'(k) + 1 < GRID_ROWS);
        cmd.use_rd      = (32'(k) < GRID_ROWS);
        cmd.compute     = (k != '0);
        cmd.sweep_shift = 1'b1;
        if (32'(k) == GRID_ROWS) begin
          state_next = ST_DRAIN;
        end else begin
          k_next = k_plus;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_ACCESS: begin
        cmd.pt_rd  = 1'b1;
        state_next = ST_MODIFY;
      end
      ST_MODIFY: begin
        cmd.pt_upd = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("controller state not one-hot");

  a_step_primes: assert property (@(posedge clk) disable iff (rst)
    accept && (s_tuser == KIND_STEP) |=> state == ST_PRIME)
    else $error("step item did not start a sweep");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over a waiting item");

  a_sweep_addr: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_rd |-> 32'(rd_addr) < GRID_ROWS)
    else $error("sweep read beyond last row");

  a_compute_addr: assert property (@(posedge clk) disable iff (rst)
    cmd.compute |-> 32'(wr_addr) < GRID_ROWS)
    else $error("sweep write beyond last row");

endmodule

`default_nettype wire

>>> rtl/core/life_grid_generation_step.sv
// top level of the bounded b3/s23 life grid block
//
// items enter on the s_ channel: s_tuser carries the kind (load a cell,
// step one generation, read a cell), s_tdata the cell address and value.
// each item gives exactly one result item on the m_ channel carrying the
// read cell state, the live count after a step and the extinct flag.
// one item is worked at a time; s_tready is high while the block is idle.
// load and read go through the access, modify and done states; unused kinds
// go straight to done. a step sweeps the grid one row per cycle through a
// three-row window over the single read port of the row memory, and the
// next item can be accepted as soon as the result is loaded.
// the result sits in an output register; a new item is accepted while it
// waits, and a finished result holds until m_tready frees the register.
// reset marks every row dead at once through per-row valid bits, so the
// block takes items in the first cycle after reset.
`default_nettype none

module life_grid_generation_step
  import lgs_pkg::*;
#(
  parameter int GRID_ROWS = DEF_GRID_ROWS,
  parameter int GRID_COLS = DEF_GRID_COLS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // row[4:0], col[9:5], alive_in[10], zero fill
  input  wire logic [S_DATA_W-1:0] s_tdata,
  // kind[1:0]
  input  wire logic [S_USER_W-1:0] s_tuser,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // cell_alive[0], live_count[11:1], extinct[12], zero fill
  output logic [M_DATA_W-1:0]      m_tdata
);

  localparam int ROW_W = $clog2(GRID_ROWS);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [ROW_W-1:0] rd_addr;
  logic [ROW_W-1:0] wr_addr;

  lgs_ctrl #(
    .GRID_ROWS(GRID_ROWS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .stat    (stat),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr)
  );

  lgs_datapath #(
    .GRID_ROWS(GRID_ROWS),
    .GRID_COLS(GRID_COLS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule

`default_nettype wire
